[hdl/daylight_color_interpolator_defines.svh]
// Assertion macros for the daylight color interpolator checker.
// Uses i_clk and i_rst_n from the module that expands them.
`ifndef DAYLIGHT_COLOR_INTERPOLATOR_DEFINES_SVH
`define DAYLIGHT_COLOR_INTERPOLATOR_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DCI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// An antecedent that implies a consequent, which may carry a delay.
`define DCI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

[hdl/dci_pkg.sv]
// Shared types and constants of the daylight color interpolator.
// Holds the keyframe table and the datapath widths; no dependencies.
`default_nettype none

package dci_pkg;

    localparam int KF_TABLE_SIZE = 9;
    localparam int DAY_MINUTES = 1440;
    localparam logic [23:0] FALLBACK_COLOR = 24'hf7f3e9;
    localparam logic [6:0] FALLBACK_BRIGHTNESS = 7'd100;

    // Widths of the minute datapath and the reciprocal divider.
    localparam int MIN_W = 11;
    localparam int MM_W = 12;
    localparam int EL_W = 11;
    localparam int SPAN_W = 11;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W = 15;
    localparam int NUM_W = 19;
    localparam int CHAN_COUNT = 4;
    localparam int HOUR_MAX = 23;
    localparam int MINUTE_MAX = 59;
    localparam int MINUTES_PER_HOUR = 60;

    // Keyframe table: minute of day, packed color and brightness.
    localparam int KF_AT [KF_TABLE_SIZE] = '{
        0, 300, 360, 480, 720, 1020, 1140, 1260, 1380
    };
    localparam logic [23:0] KF_RGB [KF_TABLE_SIZE] = '{
        24'h121728, 24'h2b3045, 24'hf4d8b8, 24'hf7f3e9, 24'hf8f5ed,
        24'hf3e7d6, 24'hc98e79, 24'h30344b, 24'h161b2a
    };
    localparam logic [6:0] KF_LEVEL [KF_TABLE_SIZE] = '{
        7'd28, 7'd38, 7'd55, 7'd82, 7'd100, 7'd86, 7'd60, 7'd42, 7'd30
    };

    // Position within the chosen segment and the segment's divider constants.
    typedef struct packed {
        logic [EL_W-1:0]    el;
        logic [SPAN_W-1:0]  span;
        logic [RECIP_W-1:0] recip;
    } t_seg;

endpackage

`default_nettype wire

[hdl/daylight_color_interpolator.sv]
// Daylight color interpolator: an accepted start passes r_v1 to r_v4 and r_strobe before the result strobes out.
// Throughput is one item per cycle; busy stays low, since every stage moves each cycle.
// The reciprocal multiply and its correction set the stage count.
// Synchronous active-low reset clears the valid bits; the payload registers are not reset.
// Uses dci_pkg and dci_lerp_lane.
`default_nettype none

module daylight_color_interpolator
    import dci_pkg::*;
#(
    parameter int KEYFRAME_COUNT = 9
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  i_hour,
    input  wire logic [5:0]  i_minute_of_hour,
    input  wire logic        i_time_valid,
    output logic             o_strobe,
    output logic      [23:0] o_color,
    output logic      [6:0]  o_brightness
);

    localparam int KF_N = (KEYFRAME_COUNT < 2) ? 2 :
                          ((KEYFRAME_COUNT > KF_TABLE_SIZE) ? KF_TABLE_SIZE : KEYFRAME_COUNT);

    logic                r_v1, r_v2, r_v3, r_v4, r_strobe;
    logic                r_fb1, r_fb2, r_fb3, r_fb4;
    logic [MIN_W-1:0]    r_min;
    logic                n_fb1;
    logic [MIN_W-1:0]    n_min;
    logic [KF_N-1:0]     c_hit;
    logic [EL_W-1:0]     c_el [KF_N];
    logic [SPAN_W-1:0]   c_span [KF_N];
    logic [RECIP_W-1:0]  c_recip [KF_N];
    t_seg                n_seg, r_seg;
    logic [7:0]          n_lo [CHAN_COUNT];
    logic [7:0]          n_hi [CHAN_COUNT];
    logic [7:0]          r_lo [CHAN_COUNT];
    logic [7:0]          r_hi [CHAN_COUNT];
    logic                n_fb2;
    logic [7:0]          c_value [CHAN_COUNT];
    logic [23:0]         r_color;
    logic [6:0]          r_bright;

    assign busy = 1'b0;

    // Stage 1: minute of day and the fallback check.
    always_comb begin
        n_fb1 = !i_time_valid || (i_hour > 5'(HOUR_MAX)) ||
                (i_minute_of_hour > 6'(MINUTE_MAX));
        n_min = MIN_W'(i_hour) * MIN_W'(MINUTES_PER_HOUR) + MIN_W'(i_minute_of_hour);
    end

    always_ff @(posedge i_clk) begin
        r_min <= n_min;
        r_fb1 <= n_fb1;
    end

    // Per-segment range check, elapsed minutes and divider constants.
    for (genvar gi = 0; gi < KF_N; gi++) begin : g_seg
        localparam int NXT = (gi + 1) % KF_N;
        localparam int IS_LAST = (gi == KF_N - 1) ? 1 : 0;
        localparam int AT_S = KF_AT[gi];
        localparam int AT_E = KF_AT[NXT] + IS_LAST * DAY_MINUTES;
        localparam int SPAN = AT_E - AT_S;
        localparam int RECIP = (1 << RECIP_SHIFT) / SPAN;
        logic [MM_W-1:0] mm;

        if (IS_LAST == 1) begin : g_wrap
            assign mm = (r_min < MIN_W'(AT_S)) ? (MM_W'(r_min) + MM_W'(DAY_MINUTES))
                                               : MM_W'(r_min);
        end else begin : g_plain
            assign mm = MM_W'(r_min);
        end

        assign c_hit[gi]   = (mm >= MM_W'(AT_S)) && (mm <= MM_W'(AT_E));
        assign c_el[gi]    = EL_W'(mm - MM_W'(AT_S));
        assign c_span[gi]  = SPAN_W'(SPAN);
        assign c_recip[gi] = RECIP_W'(RECIP);
    end

    // Stage 2: pick the first segment that holds the minute.
    always_comb begin
        n_seg.el    = c_el[0];
        n_seg.span  = c_span[0];
        n_seg.recip = c_recip[0];
        for (int c = 0; c < CHAN_COUNT; c++) begin
            n_lo[c] = 8'd0;
            n_hi[c] = 8'd0;
        end
        for (int i = KF_N - 1; i >= 0; i--) begin
            if (c_hit[i]) begin
                n_seg.el    = c_el[i];
                n_seg.span  = c_span[i];
                n_seg.recip = c_recip[i];
                n_lo[0] = KF_RGB[i][23:16];
                n_lo[1] = KF_RGB[i][15:8];
                n_lo[2] = KF_RGB[i][7:0];
                n_lo[3] = {1'b0, KF_LEVEL[i]};
                n_hi[0] = KF_RGB[(i + 1) % KF_N][23:16];
                n_hi[1] = KF_RGB[(i + 1) % KF_N][15:8];
                n_hi[2] = KF_RGB[(i + 1) % KF_N][7:0];
                n_hi[3] = {1'b0, KF_LEVEL[(i + 1) % KF_N]};
            end
        end
        n_fb2 = r_fb1 || !(|c_hit);
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
        r_fb2 <= n_fb2;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            r_lo[c] <= n_lo[c];
            r_hi[c] <= n_hi[c];
        end
    end

    // Stages 3 and 4: one blend lane each for red, green, blue and brightness.
    for (genvar gc = 0; gc < CHAN_COUNT; gc++) begin : g_lane
        dci_lerp_lane u_lane (
            .i_clk   (i_clk),
            .i_lo    (r_lo[gc]),
            .i_hi    (r_hi[gc]),
            .i_seg   (r_seg),
            .o_value (c_value[gc])
        );
    end

    // The fallback flag follows the lanes' two register stages.
    always_ff @(posedge i_clk) begin
        r_fb3 <= r_fb2;
        r_fb4 <= r_fb3;
    end

    // Output register: blended result or the fallback style.
    always_ff @(posedge i_clk) begin
        if (r_fb4) begin
            r_color  <= FALLBACK_COLOR;
            r_bright <= FALLBACK_BRIGHTNESS;
        end else begin
            r_color  <= {c_value[0], c_value[1], c_value[2]};
            r_bright <= c_value[3][6:0];
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= start && !busy;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_strobe <= r_v4;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_color      = r_color;
    assign o_brightness = r_bright;

endmodule

`default_nettype wire

[hdl/dci_lerp_lane.sv]
// One channel of the interpolator: rounded linear blend of two bytes.
// Two register stages, then the final correction step; uses dci_pkg.
`default_nettype none

module dci_lerp_lane
    import dci_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [7:0]  i_lo,
    input  wire logic [7:0]  i_hi,
    input  wire t_seg        i_seg,
    output logic      [7:0]  o_value
);

    logic [7:0]              n_mag;
    logic                    n_neg;
    logic [NUM_W-1:0]        n_num;
    logic [NUM_W-1:0]        r_num3;
    logic                    r_neg3;
    logic [7:0]              r_lo3;
    logic [SPAN_W-1:0]       r_span3;
    logic [RECIP_W-1:0]      r_recip3;
    logic [NUM_W+RECIP_W-1:0] n_prod;
    logic [7:0]              r_qest4;
    logic [NUM_W-1:0]        r_num4;
    logic                    r_neg4;
    logic [7:0]              r_lo4;
    logic [SPAN_W-1:0]       r_span4;
    logic [NUM_W-1:0]        n_rem;
    logic [7:0]              n_quot;

    // Magnitude of the rounded numerator: |d| * elapsed + span / 2.
    always_comb begin
        n_neg = (i_hi < i_lo);
        n_mag = n_neg ? (i_lo - i_hi) : (i_hi - i_lo);
        n_num = NUM_W'(n_mag) * NUM_W'(i_seg.el) + NUM_W'(i_seg.span >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_num3   <= n_num;
        r_neg3   <= n_neg;
        r_lo3    <= i_lo;
        r_span3  <= i_seg.span;
        r_recip3 <= i_seg.recip;
    end

    // Quotient estimate by the segment's reciprocal; it is low by at most one.
    assign n_prod = (NUM_W+RECIP_W)'(r_num3) * (NUM_W+RECIP_W)'(r_recip3);

    always_ff @(posedge i_clk) begin
        r_qest4 <= n_prod[RECIP_SHIFT +: 8];
        r_num4  <= r_num3;
        r_neg4  <= r_neg3;
        r_lo4   <= r_lo3;
        r_span4 <= r_span3;
    end

    // Fix the estimate with one compare, then apply the sign of the step.
    always_comb begin
        n_rem = r_num4 - NUM_W'(r_qest4) * NUM_W'(r_span4);
        n_quot = (n_rem >= NUM_W'(r_span4)) ? (r_qest4 + 8'd1) : r_qest4;
        o_value = r_neg4 ? (r_lo4 - n_quot) : (r_lo4 + n_quot);
    end

endmodule

`default_nettype wire

[hdl/dci_checker.sv]
// Port-level checks of the daylight color interpolator, bound to the top level.
// Uses dci_pkg and the assertion macros in daylight_color_interpolator_defines.svh.
`default_nettype none

`include "daylight_color_interpolator_defines.svh"

module dci_checker
    import dci_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [4:0]  i_hour,
    input wire logic [5:0]  i_minute_of_hour,
    input wire logic        i_time_valid,
    input wire logic        o_strobe,
    input wire logic [23:0] o_color,
    input wire logic [6:0]  o_brightness
);

    logic c_accept;
    logic c_bad_time;

    assign c_accept   = start && !busy;
    assign c_bad_time = !i_time_valid || (i_hour > 5'(HOUR_MAX)) ||
                        (i_minute_of_hour > 6'(MINUTE_MAX));

    // Every accepted beat gives a result strobe, and no strobe comes without one.
    `DCI_ASSERT_IMPLY(a_accept_strobe, c_accept, ##5 o_strobe, "accepted beat lost")
    `DCI_ASSERT_IMPLY(a_no_phantom, !c_accept, ##5 !o_strobe, "strobe without a beat")

    // An unknown or out-of-range time gives the fallback style.
    `DCI_ASSERT_IMPLY(a_fallback, c_accept && c_bad_time,
        ##5 (o_color == FALLBACK_COLOR && o_brightness == FALLBACK_BRIGHTNESS),
        "fallback style wrong")

    // Brightness never exceeds full scale on a result beat.
    `DCI_ASSERT_ALWAYS(a_bright_range, !o_strobe || o_brightness <= FALLBACK_BRIGHTNESS,
        "brightness out of range")

endmodule

bind daylight_color_interpolator dci_checker u_dci_checker (.*);

`default_nettype wire
